// ===== rtl/core/wprj_pkg.sv =====
`timescale 1ns / 1ps

package wprj_pkg;

    localparam int WORD_W     = 32;
    localparam int UNC_W      = 31;
    localparam int ACC_W      = 64;
    localparam int NT_W       = 3;
    localparam int COEFF_REGS = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int DIV_STEPS  = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_TERMS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_3   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_4   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_5   = 3'd6;

    typedef struct packed {
        logic signed [WORD_W-1:0] abscissa;
        logic signed [WORD_W-1:0] measured;
        logic [UNC_W-1:0]         uncertainty;
        logic                     last_point;
    } in_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] residual;
        logic signed [WORD_W-1:0] jac_0;
        logic signed [WORD_W-1:0] jac_1;
        logic signed [WORD_W-1:0] jac_2;
        logic signed [WORD_W-1:0] jac_3;
        logic signed [WORD_W-1:0] jac_4;
        logic signed [WORD_W-1:0] jac_5;
        logic                     divide_error;
        logic                     last_out;
    } out_item_t;

    typedef struct packed {
        logic [UNC_W-1:0] unc;
        logic             last;
    } div_side_t;

    // One division lane: partial remainder and the dividend bits that are
    // shifted out while quotient bits are shifted in.
    typedef struct packed {
        logic             neg;
        logic             ovf;
        logic [UNC_W-1:0] rem;
        logic [WORD_W-1:0] nq;
    } div_lane_t;

endpackage

// ===== rtl/core/wprj_poly_cell.sv =====
`timescale 1ns / 1ps

module wprj_poly_cell import wprj_pkg::*; #(
    parameter int MAX_TERMS = 6,
    parameter int FRAC_BITS = 16,
    parameter int CELL_IDX  = 0
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     advance,
    input  logic signed [WORD_W-1:0] coeff,
    input  logic                     used,
    input  logic                     valid_in,
    input  in_item_t                 side_in,
    input  logic signed [WORD_W-1:0] p_in,
    input  logic signed [ACC_W-1:0]  term_in,
    input  logic signed [ACC_W-1:0]  acc_in,
    input  logic signed [WORD_W-1:0] jac_in [MAX_TERMS],
    output logic                     valid_out,
    output in_item_t                 side_out,
    output logic signed [WORD_W-1:0] p_out,
    output logic signed [ACC_W-1:0]  term_out,
    output logic signed [ACC_W-1:0]  acc_out,
    output logic signed [WORD_W-1:0] jac_out [MAX_TERMS]
);

    localparam logic signed [ACC_W-1:0] BIAS = (64'sd1 <<< FRAC_BITS) - 64'sd1;

    // Product scaled back by the fraction bits, rounded toward zero.
    function automatic logic signed [ACC_W-1:0] qtrunc(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] b;
        b = v[ACC_W-1] ? BIAS : '0;
        return (v + b) >>> FRAC_BITS;
    endfunction

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic in_range;
        in_range = (&v[ACC_W-1:WORD_W-1]) || !(|v[ACC_W-1:WORD_W-1]);
        if (in_range) begin
            return v[WORD_W-1:0];
        end else if (v[ACC_W-1]) begin
            return {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            return {1'b0, {(WORD_W-1){1'b1}}};
        end
    endfunction

    logic                     a_valid_reg;
    in_item_t                 a_side_reg;
    logic signed [ACC_W-1:0]  a_prod_p_reg;
    logic signed [ACC_W-1:0]  a_prod_c_reg;
    logic signed [ACC_W-1:0]  a_acc_reg;
    logic                     a_used_reg;
    logic signed [WORD_W-1:0] a_jac_reg  [MAX_TERMS];
    logic signed [WORD_W-1:0] a_jac_next [MAX_TERMS];

    logic                     b_valid_reg;
    in_item_t                 b_side_reg;
    logic signed [WORD_W-1:0] b_p_reg;
    logic signed [ACC_W-1:0]  b_term_reg;
    logic signed [ACC_W-1:0]  b_acc_reg;
    logic signed [WORD_W-1:0] b_jac_reg [MAX_TERMS];

    always_comb begin
        a_jac_next           = jac_in;
        a_jac_next[CELL_IDX] = used ? p_in : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg <= valid_in;
            b_valid_reg <= a_valid_reg;
        end
    end

    // The multipliers sit in the first half; scaling, saturation and the
    // term mask in the second. The accumulator adds the term of the cell
    // before, which arrives already registered.
    always_ff @(posedge aclk) begin
        if (advance) begin
            a_side_reg   <= side_in;
            a_prod_p_reg <= ACC_W'(p_in) * ACC_W'(side_in.abscissa);
            a_prod_c_reg <= ACC_W'(coeff) * ACC_W'(p_in);
            a_acc_reg    <= acc_in + term_in;
            a_used_reg   <= used;
            a_jac_reg    <= a_jac_next;

            b_side_reg <= a_side_reg;
            b_p_reg    <= sat32(qtrunc(a_prod_p_reg));
            b_term_reg <= a_used_reg ? qtrunc(a_prod_c_reg) : '0;
            b_acc_reg  <= a_acc_reg;
            b_jac_reg  <= a_jac_reg;
        end
    end

    assign valid_out = b_valid_reg;
    assign side_out  = b_side_reg;
    assign p_out     = b_p_reg;
    assign term_out  = b_term_reg;
    assign acc_out   = b_acc_reg;
    assign jac_out   = b_jac_reg;

endmodule

// ===== rtl/core/wprj_div_cell.sv =====
`timescale 1ns / 1ps

module wprj_div_cell import wprj_pkg::*; #(
    parameter int NUM_LANES = 7
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      advance,
    input  logic      valid_in,
    input  div_side_t side_in,
    input  div_lane_t lane_in  [NUM_LANES],
    output logic      valid_out,
    output div_side_t side_out,
    output div_lane_t lane_out [NUM_LANES]
);

    logic      valid_reg;
    div_side_t side_reg;
    div_lane_t lane_reg  [NUM_LANES];
    div_lane_t lane_next [NUM_LANES];

    // One restoring step per lane: bring down the next dividend bit and
    // subtract the divisor where it fits.
    always_comb begin
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] d;
        logic [WORD_W-1:0] diff;
        logic              ge;
        for (int i = 0; i < NUM_LANES; i++) begin
            w    = {lane_in[i].rem, lane_in[i].nq[WORD_W-1]};
            d    = {1'b0, side_in.unc};
            diff = w - d;
            ge   = (w >= d);
            lane_next[i].neg = lane_in[i].neg;
            lane_next[i].ovf = lane_in[i].ovf;
            lane_next[i].rem = ge ? diff[UNC_W-1:0] : w[UNC_W-1:0];
            lane_next[i].nq  = {lane_in[i].nq[WORD_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            side_reg <= side_in;
            lane_reg <= lane_next;
        end
    end

    assign valid_out = valid_reg;
    assign side_out  = side_reg;
    assign lane_out  = lane_reg;

endmodule

// ===== rtl/core/weighted_poly_residual_jacobian_unit.sv =====
`timescale 1ns / 1ps

// Weighted polynomial residual and Jacobian row, signed fixed point.
// Input channel s_valid/s_ready/s_item carries one data point per transfer;
// the result channel m_valid/m_ready/m_item returns exactly one result per
// point, in order. Coefficients and the term count are written through the
// cfg_wr_en/cfg_index/cfg_wdata port; the user must write them only while no
// points are in flight, which the block itself does not enforce. Each point
// passes through the polynomial cells (multiply, then scale registers), the
// sum, magnitude and divisor set-up registers, 32 one-bit division cells and
// the output register. Throughput is one point per cycle while the receiver
// keeps up; it is set by the row of division cells, each of which takes one
// quotient bit of every lane. A stalled receiver holds the output register;
// the pipeline keeps moving and accepting until a finished result is waiting
// behind the held one, and then freezes as a whole.
// Synchronous reset empties the pipeline and the output register, sets the
// term count to one and clears every coefficient.
module weighted_poly_residual_jacobian_unit import wprj_pkg::*; #(
    parameter int MAX_TERMS = 6,
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_item,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_wdata
);

    localparam int NUM_LANES = MAX_TERMS + 1;
    localparam int MAG_W     = 63 - FRAC_BITS;
    localparam int NUM_W     = MAG_W + FRAC_BITS;
    localparam logic [ACC_W-1:0] MAG_LIMIT = 64'd1 << (62 - FRAC_BITS);
    localparam logic signed [WORD_W-1:0] ONE = 32'sd1 <<< FRAC_BITS;

    // Configuration
    logic [NT_W-1:0]          num_terms_reg;
    logic signed [WORD_W-1:0] coeff_reg [COEFF_REGS];
    logic [CFG_IDX_W-1:0]     coeff_idx;
    logic [NT_W-1:0]          terms;
    logic [MAX_TERMS-1:0]     used;

    assign coeff_idx = cfg_index - CFG_COEFF_0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_terms_reg <= NT_W'(1);
            for (int k = 0; k < COEFF_REGS; k++) begin
                coeff_reg[k] <= '0;
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_index) inside
                CFG_NUM_TERMS: begin
                    num_terms_reg <= cfg_wdata[NT_W-1:0];
                end
                [CFG_COEFF_0:CFG_COEFF_5]: begin
                    coeff_reg[coeff_idx] <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    assign terms = (num_terms_reg > NT_W'(MAX_TERMS)) ? NT_W'(MAX_TERMS) : num_terms_reg;

    always_comb begin
        for (int k = 0; k < MAX_TERMS; k++) begin
            used[k] = NT_W'(k) < terms;
        end
    end

    // Flow control: everything moves together unless a finished result
    // cannot enter the output register.
    logic      advance;
    logic      m_valid_reg;
    out_item_t m_item_reg;
    out_item_t m_item_next;
    logic      div_done_valid;

    assign advance = !div_done_valid || !m_valid_reg || m_ready;
    assign s_ready = advance;

    // Polynomial cells
    logic                     pv_chain   [MAX_TERMS+1];
    in_item_t                 ps_chain   [MAX_TERMS+1];
    logic signed [WORD_W-1:0] p_chain    [MAX_TERMS];
    logic signed [ACC_W-1:0]  term_chain [MAX_TERMS+1];
    logic signed [ACC_W-1:0]  acc_chain  [MAX_TERMS+1];
    logic signed [WORD_W-1:0] jac_chain  [MAX_TERMS+1][MAX_TERMS];

    assign pv_chain[0]   = s_valid;
    assign ps_chain[0]   = s_item;
    assign p_chain[0]    = ONE;
    assign term_chain[0] = '0;
    assign acc_chain[0]  = '0;

    always_comb begin
        for (int k = 0; k < MAX_TERMS; k++) begin
            jac_chain[0][k] = '0;
        end
    end

    for (genvar g = 0; g < MAX_TERMS; g++) begin : g_poly
        if (g < MAX_TERMS - 1) begin : g_mid
            wprj_poly_cell #(
                .MAX_TERMS (MAX_TERMS),
                .FRAC_BITS (FRAC_BITS),
                .CELL_IDX  (g)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .advance   (advance),
                .coeff     (coeff_reg[g]),
                .used      (used[g]),
                .valid_in  (pv_chain[g]),
                .side_in   (ps_chain[g]),
                .p_in      (p_chain[g]),
                .term_in   (term_chain[g]),
                .acc_in    (acc_chain[g]),
                .jac_in    (jac_chain[g]),
                .valid_out (pv_chain[g+1]),
                .side_out  (ps_chain[g+1]),
                .p_out     (p_chain[g+1]),
                .term_out  (term_chain[g+1]),
                .acc_out   (acc_chain[g+1]),
                .jac_out   (jac_chain[g+1])
            );
        end else begin : g_end
            // The power after the highest term is never needed.
            wprj_poly_cell #(
                .MAX_TERMS (MAX_TERMS),
                .FRAC_BITS (FRAC_BITS),
                .CELL_IDX  (g)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .advance   (advance),
                .coeff     (coeff_reg[g]),
                .used      (used[g]),
                .valid_in  (pv_chain[g]),
                .side_in   (ps_chain[g]),
                .p_in      (p_chain[g]),
                .term_in   (term_chain[g]),
                .acc_in    (acc_chain[g]),
                .jac_in    (jac_chain[g]),
                .valid_out (pv_chain[g+1]),
                .side_out  (ps_chain[g+1]),
                .p_out     (),
                .term_out  (term_chain[g+1]),
                .acc_out   (acc_chain[g+1]),
                .jac_out   (jac_chain[g+1])
            );
        end
    end

    // Sum stage: last term in, measured value out.
    logic                     sum_valid_reg;
    div_side_t                sum_side_reg;
    logic signed [ACC_W-1:0]  res_num_reg;
    logic signed [WORD_W-1:0] sum_jac_reg [MAX_TERMS];

    // Magnitude stage: sign split and clamp of every numerator.
    logic                     mag_valid_reg;
    div_side_t                mag_side_reg;
    logic [MAG_W-1:0]         mag_reg [NUM_LANES];
    logic                     neg_reg [NUM_LANES];
    logic signed [ACC_W-1:0]  lane_num [NUM_LANES];
    logic [MAG_W-1:0]         mag_next [NUM_LANES];
    logic                     neg_next [NUM_LANES];

    always_comb begin
        logic [ACC_W-1:0] m;
        lane_num[0] = res_num_reg;
        for (int k = 0; k < MAX_TERMS; k++) begin
            lane_num[k+1] = ACC_W'(sum_jac_reg[k]);
        end
        for (int i = 0; i < NUM_LANES; i++) begin
            neg_next[i] = lane_num[i][ACC_W-1];
            m = neg_next[i] ? ACC_W'(-lane_num[i]) : ACC_W'(lane_num[i]);
            mag_next[i] = (m > MAG_LIMIT) ? MAG_LIMIT[MAG_W-1:0] : m[MAG_W-1:0];
        end
    end

    // Division set-up: scaled dividend, overflow test against the divisor
    // shifted past the quotient width.
    logic      dv_chain [DIV_STEPS+1];
    div_side_t ds_chain [DIV_STEPS+1];
    div_lane_t dl_chain [DIV_STEPS+1][NUM_LANES];
    logic      init_valid_reg;
    div_side_t init_side_reg;
    div_lane_t init_lane_reg  [NUM_LANES];
    div_lane_t init_lane_next [NUM_LANES];

    always_comb begin
        logic [NUM_W-1:0] n;
        logic [NUM_W-1:0] lim;
        lim = {mag_side_reg.unc, {WORD_W{1'b0}}};
        for (int i = 0; i < NUM_LANES; i++) begin
            n = {mag_reg[i], {FRAC_BITS{1'b0}}};
            init_lane_next[i].neg = neg_reg[i];
            init_lane_next[i].ovf = (n >= lim);
            init_lane_next[i].rem = n[NUM_W-1:WORD_W];
            init_lane_next[i].nq  = n[WORD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg  <= 1'b0;
            mag_valid_reg  <= 1'b0;
            init_valid_reg <= 1'b0;
        end else if (advance) begin
            sum_valid_reg  <= pv_chain[MAX_TERMS];
            mag_valid_reg  <= sum_valid_reg;
            init_valid_reg <= mag_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            sum_side_reg.unc  <= ps_chain[MAX_TERMS].uncertainty;
            sum_side_reg.last <= ps_chain[MAX_TERMS].last_point;
            res_num_reg <= acc_chain[MAX_TERMS] + term_chain[MAX_TERMS]
                           - ACC_W'(ps_chain[MAX_TERMS].measured);
            sum_jac_reg <= jac_chain[MAX_TERMS];

            mag_side_reg <= sum_side_reg;
            mag_reg      <= mag_next;
            neg_reg      <= neg_next;

            init_side_reg <= mag_side_reg;
            init_lane_reg <= init_lane_next;
        end
    end

    assign dv_chain[0] = init_valid_reg;
    assign ds_chain[0] = init_side_reg;
    assign dl_chain[0] = init_lane_reg;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        wprj_div_cell #(
            .NUM_LANES (NUM_LANES)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .valid_in  (dv_chain[g]),
            .side_in   (ds_chain[g]),
            .lane_in   (dl_chain[g]),
            .valid_out (dv_chain[g+1]),
            .side_out  (ds_chain[g+1]),
            .lane_out  (dl_chain[g+1])
        );
    end

    assign div_done_valid = dv_chain[DIV_STEPS];

    // Saturate each quotient and apply the sign.
    function automatic logic signed [WORD_W-1:0] sat_quot(input div_lane_t l);
        if (l.neg) begin
            if (l.ovf || (l.nq[WORD_W-1] && (|l.nq[WORD_W-2:0]))) begin
                return {1'b1, {(WORD_W-1){1'b0}}};
            end else begin
                return -l.nq;
            end
        end else begin
            if (l.ovf || l.nq[WORD_W-1]) begin
                return {1'b0, {(WORD_W-1){1'b1}}};
            end else begin
                return l.nq;
            end
        end
    endfunction

    logic                     div_zero;
    logic signed [WORD_W-1:0] lane_res [NUM_LANES];
    logic signed [WORD_W-1:0] jac_full [COEFF_REGS];

    assign div_zero = (ds_chain[DIV_STEPS].unc == '0);

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            lane_res[i] = div_zero ? '0 : sat_quot(dl_chain[DIV_STEPS][i]);
        end
    end

    for (genvar g = 0; g < COEFF_REGS; g++) begin : g_jac
        if (g < MAX_TERMS) begin : g_on
            assign jac_full[g] = lane_res[g+1];
        end else begin : g_off
            assign jac_full[g] = '0;
        end
    end

    always_comb begin
        m_item_next.residual     = lane_res[0];
        m_item_next.jac_0        = jac_full[0];
        m_item_next.jac_1        = jac_full[1];
        m_item_next.jac_2        = jac_full[2];
        m_item_next.jac_3        = jac_full[3];
        m_item_next.jac_4        = jac_full[4];
        m_item_next.jac_5        = jac_full[5];
        m_item_next.divide_error = div_zero;
        m_item_next.last_out     = ds_chain[DIV_STEPS].last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= div_done_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// ===== rtl/core/wprj_checker.sv =====
`timescale 1ns / 1ps

module wprj_checker import wprj_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // No result is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result offered straight after reset");

    // A receiver that is ready never holds up the input side.
    a_ready_path: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while the receiver is ready");

    // A result waiting on the receiver is held as it is.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("held result changed or dropped");

    // A divide error forces every numeric field to zero.
    a_div_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.divide_error |->
            m_item.residual == '0 && m_item.jac_0 == '0 && m_item.jac_1 == '0 &&
            m_item.jac_2 == '0 && m_item.jac_3 == '0 && m_item.jac_4 == '0 &&
            m_item.jac_5 == '0)
        else $error("divide error with non-zero result fields");

endmodule

bind weighted_poly_residual_jacobian_unit wprj_checker u_wprj_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
